>>> hw/rtl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, skipped during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/hsfc_pkg.sv
`default_nettype none
package hsfc_pkg;
    localparam int unsigned HALF_BIAS   = 15;
    localparam int unsigned SINGLE_BIAS = 127;

    typedef enum logic {
        ACT_H2S = 1'b0,
        ACT_S2H = 1'b1
    } t_action;

    // Decoded operand after stage 1.
    typedef struct packed {
        logic        act;
        logic        sign;
        logic        is_zero;   // result is signed zero
        logic        is_inf;    // result is signed infinity
        logic        is_nan;
        logic        is_sub;    // needs normalize (h2s) or denormalize (s2h)
        logic [7:0]  ex;        // biased result exponent for normal path
        logic [3:0]  sh;        // shift amount for subnormal path
        logic [22:0] fr;        // single-aligned fraction
    } t_dec;

    // Packed result pieces after stage 2.
    typedef struct packed {
        logic        act;
        logic        sign;
        logic [7:0]  ex;
        logic [22:0] fr;
    } t_mid;
endpackage
`default_nettype wire

>>> hw/rtl/half_single_float_converter_core.sv
// Half/single float converter.
// Input channel: i_valid/o_ready carry i_action and i_operand_bits.
//   i_action = 0: low 16 bits are a binary16, result is the binary32.
//   i_action = 1: all 32 bits are a binary32, result is the binary16 in
//   the low 16 bits (upper bits zero), truncated, no rounding.
// Output channel: o_valid/i_ready carry o_converted_bits.
// Three register stages: decode (classify, leading-one search),
// shift (normalize or denormalize), pack; o_valid is the pack stage's
// valid bit. One transaction per cycle is sustained while i_ready stays
// high.
// Each stage holds a valid bit; a stage advances when it is empty or the
// stage after it advances, so a stall on i_ready backs up through the
// pipe without loss and o_ready drops only when all stages are full and
// i_ready is low (o_ready follows i_ready combinationally).
// Synchronous active-low reset clears the valid bits; data regs are not reset.
`default_nettype none
module half_single_float_converter_core import hsfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_action,
    input  wire logic [31:0] i_operand_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_converted_bits
);
    logic        r_v1, r_v2, r_v3;
    t_dec        r_dec, n_dec;
    t_mid        r_mid, n_mid;
    logic [31:0] r_out, n_out;
    logic        adv1, adv2, adv3;

    // Pipeline enables, computed back from the output.
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;
    assign o_converted_bits = r_out;

    hsfc_decode u_decode (
        .i_act  (i_action),
        .i_bits (i_operand_bits),
        .o_dec  (n_dec)
    );

    hsfc_shift u_shift (
        .i_dec (r_dec),
        .o_mid (n_mid)
    );

    // Pack stage.
    always_comb begin
        if (r_mid.act == ACT_H2S) n_out = {r_mid.sign, r_mid.ex, r_mid.fr};
        else n_out = {16'd0, r_mid.sign, r_mid.ex[4:0], r_mid.fr[9:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
        if (adv1) r_dec <= n_dec;
        if (adv2) r_mid <= n_mid;
        if (adv3) r_out <= n_out;
    end
endmodule
`default_nettype wire

>>> hw/rtl/hsfc_decode.sv
`default_nettype none
module hsfc_decode import hsfc_pkg::*; (
    input  wire logic        i_act,
    input  wire logic [31:0] i_bits,
    output t_dec             o_dec
);
    logic [4:0]  h_ex;
    logic [9:0]  h_fr;
    logic [7:0]  s_ex;
    logic [22:0] s_fr;
    logic [8:0]  ne;     // s_ex - 112, two's complement
    logic [3:0]  lz;

    always_comb begin
        h_ex = i_bits[14:10];
        h_fr = i_bits[9:0];
        s_ex = i_bits[30:23];
        s_fr = i_bits[22:0];
        ne   = {1'b0, s_ex} - 9'(SINGLE_BIAS - HALF_BIAS);
        lz   = 4'd0;
        for (int k = 9; k >= 0; k--) begin
            if (h_fr[k] && lz == 4'd0) lz = 4'(10 - k);
        end
        o_dec = '0;
        o_dec.act = i_act;
        if (i_act == ACT_H2S) begin
            o_dec.sign = i_bits[15];
            o_dec.fr   = {h_fr, 13'd0};
            o_dec.ex   = {3'd0, h_ex} + 8'(SINGLE_BIAS - HALF_BIAS);
            if (h_ex == 5'h1F) begin
                o_dec.is_nan = (h_fr != '0);
                o_dec.is_inf = (h_fr == '0);
            end else if (h_ex == 5'd0) begin
                o_dec.is_zero = (h_fr == '0);
                o_dec.is_sub  = (h_fr != '0);
                o_dec.sh      = lz;
            end
        end else begin
            o_dec.sign = i_bits[31];
            o_dec.fr   = s_fr;
            o_dec.ex   = {3'd0, ne[4:0]};
            if (s_ex == 8'hFF) begin
                o_dec.is_nan = (s_fr != '0);
                o_dec.is_inf = (s_fr == '0);
            end else if (s_ex == 8'd0) begin
                o_dec.is_zero = 1'b1;
            end else if (!ne[8] && ne >= 9'd31) begin
                o_dec.is_inf = 1'b1;
            end else if (ne[8] || ne == 9'd0) begin
                if ($signed(ne) < -9'sd10) o_dec.is_zero = 1'b1;
                else begin
                    o_dec.is_sub = 1'b1;
                    o_dec.sh     = 4'(9'd1 - ne);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/hsfc_shift.sv
`default_nettype none
module hsfc_shift import hsfc_pkg::*; (
    input  t_dec i_dec,
    output t_mid o_mid
);
    logic [23:0] man;

    always_comb begin
        man = {1'b1, i_dec.fr};
        o_mid      = '0;
        o_mid.act  = i_dec.act;
        o_mid.sign = i_dec.sign;
        if (i_dec.act == ACT_H2S) begin
            if (i_dec.is_nan) begin
                o_mid.ex = 8'hFF;
                o_mid.fr = i_dec.fr | 23'd1;
            end else if (i_dec.is_inf) begin
                o_mid.ex = 8'hFF;
            end else if (i_dec.is_sub) begin
                o_mid.ex = 8'(SINGLE_BIAS - HALF_BIAS + 1) - {4'd0, i_dec.sh};
                o_mid.fr = i_dec.fr << i_dec.sh;
            end else if (!i_dec.is_zero) begin
                o_mid.ex = i_dec.ex;
                o_mid.fr = i_dec.fr;
            end
        end else begin
            if (i_dec.is_nan) begin
                o_mid.ex = 8'h1F;
                o_mid.fr = {13'd0, i_dec.fr[22:13] | 10'd1};
            end else if (i_dec.is_inf) begin
                o_mid.ex = 8'h1F;
            end else if (i_dec.is_sub) begin
                man = man >> i_dec.sh;
                o_mid.fr = {13'd0, man[22:13]};
            end else if (!i_dec.is_zero) begin
                o_mid.ex = i_dec.ex;
                o_mid.fr = {13'd0, i_dec.fr[22:13]};
            end
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/hsfc_checker.sv
`default_nettype none
`include "assert_macros.svh"
module hsfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_converted_bits
);
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready,
        o_valid && $stable(o_converted_bits), "result dropped or changed while stalled")
    `ASSERT_IMPL(a_ready_when_drain, i_clk, i_rst_n, !o_valid, o_ready,
        "input blocked with empty output")
    `ASSERT_IMPL(a_out_known, i_clk, i_rst_n, o_valid, !$isunknown(o_converted_bits),
        "unknown bits in result")
    `ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid,
        "input transaction withdrawn before accept")
endmodule
bind half_single_float_converter_core hsfc_checker u_hsfc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_converted_bits (o_converted_bits)
);
`default_nettype wire
